@@ rtl/level_meter_channel_top_macros.svh @@
// assertion macros for the level meter channel
`ifndef LEVEL_METER_CHANNEL_TOP_MACROS_SVH
`define LEVEL_METER_CHANNEL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("level meter check failed");
`define LMC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("level meter forbidden condition seen");
`else
`define LMC_ASSERT(lbl, prop)
`define LMC_NEVER(lbl, cond)
`endif
`endif

@@ rtl/lmc_pkg.sv @@
// types and constants shared by the level meter channel
`default_nettype none

package lmc_pkg;

    localparam int LVL_W      = 16;
    localparam int MS_W       = 10;
    localparam int CNT_W      = 16;
    localparam int MULT_W     = 16;
    localparam int STEP_W     = 15;
    localparam int AMT_W      = STEP_W + MULT_W;
    localparam int DIFF_W     = AMT_W + 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_W     = 5;

    localparam logic signed [LVL_W-1:0] FLOOR_RST     = -16'sd15360;
    localparam logic signed [LVL_W-1:0] CEILING_RST   = 16'sd3072;
    localparam logic signed [LVL_W-1:0] THRESHOLD_RST = 16'sd0;
    localparam logic [CNT_W-1:0]        TEXT_HOLD_RST = 16'd500;
    localparam logic [CNT_W-1:0]        PEAK_HOLD_RST = 16'd500;
    localparam logic [STEP_W-1:0]       STEP_RST      = 15'd26;

    typedef enum logic [2:0] {
        REG_FLOOR     = 3'd0,
        REG_CEILING   = 3'd1,
        REG_THRESHOLD = 3'd2,
        REG_TEXT_HOLD = 3'd3,
        REG_PEAK_HOLD = 3'd4,
        REG_STEP      = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        REQ_LEVEL = 1'b0,
        REQ_TICK  = 1'b1
    } req_kind_t;

    // meter state handed from the update stage to the output stage
    typedef struct packed {
        logic signed [LVL_W-1:0] last_level;
        logic signed [LVL_W-1:0] text_peak;
        logic                    over;
        logic signed [LVL_W-1:0] decay_peak;
    } snap_t;

endpackage

`default_nettype wire

@@ rtl/level_meter_channel_top.sv @@
// level meter channel: peak hold, decaying peak and moving average
//
//  port group | direction | word contents
//  s_         | in        | tdata: level_db[15:0], elapsed_ms[25:16]; tuser: req_type
//  m_         | out       | tdata: current, held, over, display, decaying, average
//  apb        | in/out    | six meter registers at byte address 4*index
//
// three register stages: input register, state update, divide by window depth
// into the output register; one word per cycle while the output does not stall
// and no step reload is pending; a write to decay_step holds the update stage
// while the step times multiplier product is reloaded through the multiplier
// reset is synchronous; window entries carry valid bits, so no clearing pass
// a stalled output keeps the input and update stages filled, then stops s_tready
`default_nettype none
`include "level_meter_channel_top_macros.svh"

module level_meter_channel_top
    import lmc_pkg::*;
#(
    parameter int AVG_DEPTH = 30
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // level_db[15:0], elapsed_ms[25:16], zeros
    input  logic [0:0]            s_tuser,   // req_type

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // current_level[15:0], held_peak[31:16],
                                             // over_threshold[32], display_value[48:33],
                                             // decaying_peak[64:49], average_level[80:65]

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CLOG_D   = $clog2(AVG_DEPTH);
    localparam int IDX_W    = (AVG_DEPTH > 1) ? CLOG_D : 1;
    localparam int SUM_W    = LVL_W + IDX_W;
    localparam int MAGIC_K  = SUM_W + CLOG_D;
    localparam int MAGIC_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + MAGIC_W;
    localparam int QW       = LVL_W + 1;
    localparam int PAD_W    = OUT_DATA_W - (5 * LVL_W + 1);
    localparam logic [MAGIC_W-1:0] MAGIC =
        MAGIC_W'(((64'd1 << MAGIC_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_DEPTH - 1);

    // configuration
    logic signed [LVL_W-1:0] floor_reg, ceil_reg, thr_reg;
    logic [CNT_W-1:0]        text_hold_reg, peak_hold_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    recalc_reg;
    logic                    cfg_wr;
    cfg_reg_t                cfg_sel;

    // pipeline control
    logic out_free, adv1, adv2, mid_free, adv_lvl, is_tick;

    // input register
    logic                    in_vld_reg;
    req_kind_t               in_type_reg;
    logic signed [LVL_W-1:0] in_level_reg;
    logic [MS_W-1:0]         in_ms_reg;

    // meter state
    logic signed [LVL_W-1:0] last_reg, last_next;
    logic signed [LVL_W-1:0] tpeak_reg, tpeak_next;
    logic                    over_reg, over_next;
    logic [CNT_W-1:0]        tms_reg, tms_next;
    logic signed [LVL_W-1:0] dpeak_reg, dpeak_next;
    logic [CNT_W-1:0]        dms_reg, dms_next;
    logic [MULT_W-1:0]       mult_reg, mult_next;
    logic [AMT_W-1:0]        amt_reg, amt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    // averaging window
    logic signed [LVL_W-1:0] win_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0]    win_vld_reg;
    logic [IDX_W-1:0]        idx_reg, idx_nxt;
    logic signed [LVL_W-1:0] oldest_reg, oldest;
    logic                    oldest_vld_reg;

    // stage one helpers
    logic [CNT_W:0]           tms_sum, dms_sum;
    logic [CNT_W-1:0]         tms_sat, dms_sat;
    logic signed [DIFF_W-1:0] fall;
    logic signed [LVL_W-1:0]  clamped;
    logic [MULT_W:0]          mult_plus;

    // middle and output stages
    logic                    mid_vld_reg;
    snap_t                   mid_snap_reg;
    logic signed [SUM_W-1:0] mid_sum_reg;
    logic                    sum_neg;
    logic [SUM_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [QW-1:0]           q_mag, q_signed;
    logic signed [LVL_W-1:0] avg, display;
    logic                    m_vld_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg     <= FLOOR_RST;
            ceil_reg      <= CEILING_RST;
            thr_reg       <= THRESHOLD_RST;
            text_hold_reg <= TEXT_HOLD_RST;
            peak_hold_reg <= PEAK_HOLD_RST;
            step_reg      <= STEP_RST;
            recalc_reg    <= 1'b0;
        end else begin
            recalc_reg <= cfg_wr && (cfg_sel == REG_STEP);
            if (cfg_wr) begin
                case (cfg_sel)
                    REG_FLOOR:     floor_reg     <= pwdata[LVL_W-1:0];
                    REG_CEILING:   ceil_reg      <= pwdata[LVL_W-1:0];
                    REG_THRESHOLD: thr_reg       <= pwdata[LVL_W-1:0];
                    REG_TEXT_HOLD: text_hold_reg <= pwdata[CNT_W-1:0];
                    REG_PEAK_HOLD: peak_hold_reg <= pwdata[CNT_W-1:0];
                    REG_STEP:      step_reg      <= pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_FLOOR:     prdata = {16'b0, floor_reg};
            REG_CEILING:   prdata = {16'b0, ceil_reg};
            REG_THRESHOLD: prdata = {16'b0, thr_reg};
            REG_TEXT_HOLD: prdata = {16'b0, text_hold_reg};
            REG_PEAK_HOLD: prdata = {16'b0, peak_hold_reg};
            REG_STEP:      prdata = {17'b0, step_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign out_free = !m_vld_reg || m_tready;
    assign adv2     = mid_vld_reg && out_free;
    assign mid_free = !mid_vld_reg || adv2;
    assign adv1     = in_vld_reg && mid_free && !recalc_reg;
    assign s_tready = !in_vld_reg || adv1;
    assign is_tick  = (in_type_reg == REQ_TICK);
    assign adv_lvl  = adv1 && (in_type_reg == REQ_LEVEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg  <= req_kind_t'(s_tuser[0]);
            in_level_reg <= s_tdata[LVL_W-1:0];
            in_ms_reg    <= s_tdata[LVL_W +: MS_W];
        end
    end

    // ---------------- stage one: state update ----------------
    assign tms_sum = {1'b0, tms_reg} + (CNT_W + 1)'(in_ms_reg);
    assign dms_sum = {1'b0, dms_reg} + (CNT_W + 1)'(in_ms_reg);
    assign tms_sat = tms_sum[CNT_W] ? '1 : tms_sum[CNT_W-1:0];
    assign dms_sat = dms_sum[CNT_W] ? '1 : dms_sum[CNT_W-1:0];

    assign fall = DIFF_W'(dpeak_reg) - signed'({2'b0, amt_reg});

    always_comb begin
        if (fall < DIFF_W'(floor_reg)) begin
            clamped = floor_reg;
        end else if (fall > DIFF_W'(ceil_reg)) begin
            clamped = ceil_reg;
        end else begin
            clamped = fall[LVL_W-1:0];
        end
    end

    assign mult_plus = {1'b0, mult_reg} + (MULT_W + 1)'(2);
    assign oldest    = oldest_vld_reg ? oldest_reg : '0;

    always_comb begin
        last_next  = last_reg;
        tpeak_next = tpeak_reg;
        over_next  = over_reg;
        tms_next   = tms_reg;
        dpeak_next = dpeak_reg;
        dms_next   = dms_reg;
        mult_next  = mult_reg;
        amt_next   = amt_reg;
        sum_next   = sum_reg;
        if (!is_tick) begin
            last_next = in_level_reg;
            if (in_level_reg > thr_reg) begin
                over_next = 1'b1;
                tms_next  = '0;
                if (in_level_reg > tpeak_reg) begin
                    tpeak_next = in_level_reg;
                end
            end
            if (in_level_reg > dpeak_reg) begin
                dpeak_next = in_level_reg;
                dms_next   = '0;
                mult_next  = MULT_W'(1);
                amt_next   = AMT_W'(step_reg);
            end
            sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(in_level_reg);
        end else begin
            tms_next = tms_sat;
            if (tms_sat > text_hold_reg) begin
                over_next  = (last_reg > thr_reg);
                tpeak_next = floor_reg;
            end
            dms_next = dms_sat;
            if (dms_sat > peak_hold_reg) begin
                dpeak_next = clamped;
                if (clamped <= floor_reg) begin
                    mult_next = MULT_W'(1);
                    amt_next  = AMT_W'(step_reg);
                end else if (mult_plus[MULT_W]) begin
                    mult_next = '1;
                end else begin
                    // odd multiplier grows by two, so the product grows by twice the step
                    mult_next = mult_plus[MULT_W-1:0];
                    amt_next  = amt_reg + AMT_W'({step_reg, 1'b0});
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= FLOOR_RST;
            tpeak_reg <= FLOOR_RST;
            over_reg  <= 1'b0;
            tms_reg   <= '0;
            dpeak_reg <= FLOOR_RST;
            dms_reg   <= '0;
            mult_reg  <= MULT_W'(1);
            amt_reg   <= AMT_W'(STEP_RST);
            sum_reg   <= '0;
        end else if (recalc_reg) begin
            amt_reg <= AMT_W'(step_reg) * AMT_W'(mult_reg);
        end else if (adv1) begin
            last_reg  <= last_next;
            tpeak_reg <= tpeak_next;
            over_reg  <= over_next;
            tms_reg   <= tms_next;
            dpeak_reg <= dpeak_next;
            dms_reg   <= dms_next;
            mult_reg  <= mult_next;
            amt_reg   <= amt_next;
            sum_reg   <= sum_next;
        end
    end

    // window: oldest entry is prefetched for the next write slot
    assign idx_nxt = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (adv_lvl) begin
            win_mem[idx_reg] <= in_level_reg;
            oldest_reg       <= (idx_nxt == idx_reg) ? in_level_reg : win_mem[idx_nxt];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_vld_reg    <= '0;
            oldest_vld_reg <= 1'b0;
            idx_reg        <= '0;
        end else if (adv_lvl) begin
            win_vld_reg[idx_reg] <= 1'b1;
            oldest_vld_reg       <= (idx_nxt == idx_reg) || win_vld_reg[idx_nxt];
            idx_reg              <= idx_nxt;
        end
    end

    // ---------------- middle register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= 1'b0;
        end else if (adv1) begin
            mid_vld_reg <= 1'b1;
        end else if (adv2) begin
            mid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            mid_snap_reg.last_level <= last_next;
            mid_snap_reg.text_peak  <= tpeak_next;
            mid_snap_reg.over       <= over_next;
            mid_snap_reg.decay_peak <= dpeak_next;
            mid_sum_reg             <= sum_next;
        end
    end

    // ---------------- stage two: average by reciprocal multiply ----------------
    assign sum_neg  = mid_sum_reg[SUM_W-1];
    assign mag      = sum_neg ? SUM_W'(-mid_sum_reg) : SUM_W'(mid_sum_reg);
    assign prod     = PROD_W'(mag) * PROD_W'(MAGIC);
    assign q_mag    = prod[MAGIC_K +: QW];
    assign q_signed = sum_neg ? (~q_mag + 1'b1) : q_mag;
    assign avg      = q_signed[LVL_W-1:0];
    assign display  = mid_snap_reg.over ? mid_snap_reg.text_peak : mid_snap_reg.last_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv2) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            m_data_reg <= {{PAD_W{1'b0}}, avg, mid_snap_reg.decay_peak, display,
                           mid_snap_reg.over, mid_snap_reg.text_peak,
                           mid_snap_reg.last_level};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    `LMC_ASSERT(a_amt_tracks_product, recalc_reg || (amt_reg == AMT_W'(step_reg) * AMT_W'(mult_reg)))
    `LMC_NEVER(a_mult_even, mult_reg[0] == 1'b0)
    `LMC_ASSERT(a_mid_holds, mid_vld_reg && !out_free |=> mid_vld_reg)
    `LMC_ASSERT(a_tick_keeps_sum, adv1 && is_tick |=> sum_reg == $past(sum_reg))

endmodule

`default_nettype wire
